// ===== sv/mert_pkg.sv =====
package mert_pkg;

    localparam int NODE_COUNT_DEF = 16;
    localparam int NODE_MAX       = 16;
    localparam int PAIR_REGS      = 8;
    localparam int PAIR_IDX_W     = 3;
    localparam int CFG_IDX_W      = 4;
    localparam int NODE_W         = 26;
    localparam int PAIR_W         = 2 * NODE_W;

    localparam logic [NODE_W-1:0] NODE_RESET = 26'h2240010;
    localparam logic [PAIR_W-1:0] PAIR_RESET = {NODE_RESET, NODE_RESET};

    localparam logic [4:0] CHN_ALL      = 5'd17;
    localparam logic [4:0] CHN_NONE     = 5'd0;
    localparam logic [3:0] CIN_SINGLE   = 4'hF;
    localparam logic [3:0] CIN_SYSEX_LO = 4'd4;
    localparam logic [3:0] CIN_SYSEX_HI = 4'd7;
    localparam logic [3:0] EV_VOICE_LO  = 4'd8;
    localparam logic [3:0] EV_VOICE_HI  = 4'd14;

    typedef struct packed {
        logic       hit;
        logic [7:0] dport;
        logic [7:0] ostat;
    } t_match;

    function automatic logic cin_dropped(input logic [3:0] cin);
        return (cin == CIN_SINGLE) || ((cin >= CIN_SYSEX_LO) && (cin <= CIN_SYSEX_HI));
    endfunction

endpackage

// ===== sv/midi_event_route_table.sv =====
// channel | direction | handshake              | payload
// cfg     | in        | i_cfg_we               | i_cfg_index, i_cfg_data
// in      | in        | i_in_valid/o_in_stall  | arrival port + event package
// out     | out       | o_out_valid/i_out_stall| target port + package + run_last
//
// An item is accepted in idle, then scans the NODE_COUNT nodes (one node per cycle
// through the shared match unit while no held output stalls the scan) and then flushes.
// A dropped code index is not scanned; the block stays in idle.
// A held output stalls the scan at a match while a copy is pending, and holds the flush.
// Reset is synchronous, active low; the route table resets to all nodes inactive.
module midi_event_route_table
    import mert_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PAIR_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_arrival_port,
    input  logic [3:0]           i_code_index,
    input  logic [3:0]           i_cable_number,
    input  logic [7:0]           i_status_byte,
    input  logic [7:0]           i_data_one,
    input  logic [7:0]           i_data_two,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [7:0]           o_target_port,
    output logic [3:0]           o_out_code_index,
    output logic [3:0]           o_out_cable,
    output logic [7:0]           o_out_status,
    output logic [7:0]           o_out_data_one,
    output logic [7:0]           o_out_data_two,
    output logic                 o_run_last
);

    localparam int IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NODE_COUNT - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH
    } t_state;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [PAIR_W-1:0]  r_pair [PAIR_REGS];

    logic [7:0] r_port, r_status, r_d1, r_d2;
    logic [3:0] r_cin, r_cable;

    logic       r_pend_valid, n_pend_valid;
    logic [7:0] r_pend_port, n_pend_port;
    logic [7:0] r_pend_stat, n_pend_stat;

    logic       r_out_valid, n_out_valid;
    logic       r_out_last, n_out_last;
    logic [7:0] r_out_port, n_out_port;
    logic [7:0] r_out_stat, n_out_stat;
    logic       out_load;

    logic [3:0]        node_num;
    logic [PAIR_W-1:0] pair_word;
    logic [NODE_W-1:0] node_word;
    t_match            match;
    logic              out_free;
    logic              in_acc;

    assign node_num  = 4'(r_idx);
    assign pair_word = r_pair[node_num[3:1]];
    assign node_word = node_num[0] ? pair_word[PAIR_W-1:NODE_W] : pair_word[NODE_W-1:0];

    mert_match u_match (
        .i_node   (node_word),
        .i_port   (r_port),
        .i_status (r_status),
        .o_match  (match)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_pend_valid = r_pend_valid;
        n_pend_port  = r_pend_port;
        n_pend_stat  = r_pend_stat;
        out_load     = 1'b0;
        n_out_last   = r_out_last;
        n_out_port   = r_out_port;
        n_out_stat   = r_out_stat;
        case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (in_acc && !cin_dropped(i_code_index)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!match.hit || !r_pend_valid || out_free) begin
                    if (match.hit) begin
                        n_pend_valid = 1'b1;
                        n_pend_port  = match.dport;
                        n_pend_stat  = match.ostat;
                        if (r_pend_valid) begin
                            out_load   = 1'b1;
                            n_out_last = 1'b0;
                            n_out_port = r_pend_port;
                            n_out_stat = r_pend_stat;
                        end
                    end
                    if (r_idx == IDX_LAST) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    out_load     = 1'b1;
                    n_out_last   = 1'b1;
                    n_out_port   = r_pend_port;
                    n_out_stat   = r_pend_stat;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = out_free ? out_load : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < PAIR_REGS; i++) begin
                r_pair[i] <= PAIR_RESET;
            end
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we && (i_cfg_index < CFG_IDX_W'(PAIR_REGS))) begin
                r_pair[i_cfg_index[PAIR_IDX_W-1:0]] <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_port <= n_pend_port;
        r_pend_stat <= n_pend_stat;
        if (in_acc) begin
            r_port   <= i_arrival_port;
            r_cin    <= i_code_index;
            r_cable  <= i_cable_number;
            r_status <= i_status_byte;
            r_d1     <= i_data_one;
            r_d2     <= i_data_two;
        end
        if (out_load && out_free) begin
            r_out_last <= n_out_last;
            r_out_port <= n_out_port;
            r_out_stat <= n_out_stat;
            o_out_code_index <= r_cin;
            o_out_cable      <= r_cable;
            o_out_data_one   <= r_d1;
            o_out_data_two   <= r_d2;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_target_port = r_out_port;
    assign o_out_status  = r_out_stat;
    assign o_run_last    = r_out_last;

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_valid)
        else $error("pending copy left in idle");

    a_flush_emits_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH && r_pend_valid && out_free) |=> (o_out_valid && o_run_last))
        else $error("final copy not flagged last");

    a_scan_emits_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && match.hit && r_pend_valid && out_free)
        |=> (o_out_valid && !o_run_last))
        else $error("superseded copy flagged last");

    a_stall_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |=> (r_state != S_IDLE))
        else $error("scan ended without flush");

endmodule

// ===== sv/mert_match.sv =====
module mert_match
    import mert_pkg::*;
(
    input  logic [NODE_W-1:0] i_node,
    input  logic [7:0]        i_port,
    input  logic [7:0]        i_status,
    output t_match            o_match
);

    logic [7:0] sport;
    logic [4:0] schn;
    logic [7:0] dport;
    logic [4:0] dchn;
    logic [3:0] ev;
    logic [4:0] chn_p1;
    logic       active;
    logic       voice;
    logic [3:0] dchn_m1;

    assign sport   = i_node[7:0];
    assign schn    = i_node[12:8];
    assign dport   = i_node[20:13];
    assign dchn    = i_node[25:21];
    assign ev      = i_status[7:4];
    assign chn_p1  = {1'b0, i_status[3:0]} + 5'd1;
    assign dchn_m1 = dchn[3:0] - 4'd1;
    assign active  = (schn != CHN_NONE) && (dchn != CHN_NONE) && (sport == i_port);
    assign voice   = (ev >= EV_VOICE_LO) && (ev <= EV_VOICE_HI);

    always_comb begin
        o_match.dport = dport;
        o_match.ostat = i_status;
        if (voice) begin
            o_match.hit = active && ((schn == CHN_ALL) || (chn_p1 == schn));
            if (dchn < CHN_ALL) begin
                o_match.ostat = {ev, dchn_m1};
            end
        end else begin
            o_match.hit = active && (dchn >= CHN_ALL);
        end
    end

endmodule

// ===== dv/midi_event_route_table_test.sv =====
`timescale 1ns / 1ps

module midi_event_route_table_test;
    import mert_pkg::*;

    localparam int NODES     = NODE_COUNT_DEF;
    localparam int SETTLE    = 2 * (NODES + 2) + 4;
    localparam int CYCLE_CAP = 200000;
    localparam int CFG_SLOTS = 1 << CFG_IDX_W;

    typedef struct packed {
        logic [7:0] port;
        logic [3:0] cin;
        logic [3:0] cable;
        logic [7:0] status;
        logic [7:0] d1;
        logic [7:0] d2;
    } midi_pkt_t;

    typedef struct packed {
        logic [7:0] dport;
        logic [3:0] cin;
        logic [3:0] cable;
        logic [7:0] status;
        logic [7:0] d1;
        logic [7:0] d2;
        logic       last;
    } fwd_copy_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PAIR_W-1:0]    cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    midi_pkt_t            in_pkt    = '0;
    logic                 out_stall = 1'b0;
    logic                 quiet     = 1'b0;

    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [7:0]           o_target_port;
    logic [3:0]           o_out_code_index;
    logic [3:0]           o_out_cable;
    logic [7:0]           o_out_status;
    logic [7:0]           o_out_data_one;
    logic [7:0]           o_out_data_two;
    logic                 o_run_last;

    logic [PAIR_W-1:0]    route_copy [PAIR_REGS];
    logic [NODE_W-1:0]    staged_nodes [NODE_MAX];
    logic [7:0]           port_pool [4];
    midi_pkt_t            pending_pkts [$];
    fwd_copy_t            fwd_expect [$];
    fwd_copy_t            want_copy;
    int                   fault_count = 0;
    int                   cycle_count = 0;

    midi_event_route_table u_top (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_stall       (o_in_stall),
        .i_arrival_port   (in_pkt.port),
        .i_code_index     (in_pkt.cin),
        .i_cable_number   (in_pkt.cable),
        .i_status_byte    (in_pkt.status),
        .i_data_one       (in_pkt.d1),
        .i_data_two       (in_pkt.d2),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (out_stall),
        .o_target_port    (o_target_port),
        .o_out_code_index (o_out_code_index),
        .o_out_cable      (o_out_cable),
        .o_out_status     (o_out_status),
        .o_out_data_one   (o_out_data_one),
        .o_out_data_two   (o_out_data_two),
        .o_run_last       (o_run_last)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [NODE_W-1:0] mk_node(input logic [7:0] sp, input logic [4:0] sc,
                                                  input logic [7:0] dp, input logic [4:0] dc);
        return {dc, dp, sc, sp};
    endfunction

    function automatic midi_pkt_t mk_pkt(input logic [7:0] port, input logic [3:0] cin,
                                         input logic [3:0] cable, input logic [7:0] status,
                                         input logic [7:0] d1, input logic [7:0] d2);
        midi_pkt_t p;
        p.port   = port;
        p.cin    = cin;
        p.cable  = cable;
        p.status = status;
        p.d1     = d1;
        p.d2     = d2;
        return p;
    endfunction

    // expected forwarded copies of one package, in node order
    function automatic void route_pkt(input midi_pkt_t p);
        logic [PAIR_W-1:0] pair;
        logic [NODE_W-1:0] w;
        logic [4:0]        schn;
        logic [4:0]        dchn;
        logic [7:0]        ostat;
        logic              voice;
        fwd_copy_t         c;
        fwd_copy_t         hits [$];
        voice = (p.status[7:4] >= EV_VOICE_LO) && (p.status[7:4] <= EV_VOICE_HI);
        if (p.cin == CIN_SINGLE || (p.cin >= CIN_SYSEX_LO && p.cin <= CIN_SYSEX_HI)) begin
            return;
        end
        for (int i = 0; i < NODES; i++) begin
            pair = route_copy[i >> 1];
            w    = i[0] ? pair[PAIR_W-1:NODE_W] : pair[NODE_W-1:0];
            schn = w[12:8];
            dchn = w[25:21];
            if (schn == CHN_NONE || dchn == CHN_NONE || w[7:0] != p.port) begin
                continue;
            end
            ostat = p.status;
            if (voice) begin
                if (schn != CHN_ALL && ({1'b0, p.status[3:0]} + 5'd1) != schn) begin
                    continue;
                end
                if (dchn < CHN_ALL) begin
                    ostat[3:0] = dchn[3:0] - 4'd1;
                end
            end else if (dchn < CHN_ALL) begin
                continue;
            end
            c.dport  = w[20:13];
            c.cin    = p.cin;
            c.cable  = p.cable;
            c.status = ostat;
            c.d1     = p.d1;
            c.d2     = p.d2;
            c.last   = 1'b0;
            hits.push_back(c);
        end
        if (hits.size() != 0) begin
            hits[hits.size() - 1].last = 1'b1;
        end
        foreach (hits[k]) begin
            fwd_expect.push_back(hits[k]);
        end
    endfunction

    function automatic logic [NODE_W-1:0] rand_node();
        logic [7:0] sp;
        logic [4:0] sc;
        logic [4:0] dc;
        int         r;
        r  = $urandom_range(99);
        sp = (r < 85) ? port_pool[$urandom_range(3)] : 8'($urandom);
        r  = $urandom_range(99);
        if (r < 10)      sc = CHN_NONE;
        else if (r < 30) sc = CHN_ALL;
        else if (r < 80) sc = 5'($urandom_range(16, 1));
        else             sc = 5'($urandom_range(31, 18));
        r  = $urandom_range(99);
        if (r < 10)      dc = CHN_NONE;
        else if (r < 25) dc = CHN_ALL;
        else if (r < 35) dc = 5'($urandom_range(31, 18));
        else             dc = 5'($urandom_range(16, 1));
        return mk_node(sp, sc, 8'($urandom), dc);
    endfunction

    function automatic midi_pkt_t rand_pkt();
        midi_pkt_t p;
        int        r;
        r      = $urandom_range(99);
        p.port = (r < 85) ? port_pool[$urandom_range(3)] : 8'($urandom);
        r      = $urandom_range(99);
        if (r < 85) begin
            p.cin = 4'($urandom_range(10));
            if (p.cin > 4'd3) p.cin = p.cin + 4'd4;
        end else begin
            p.cin = 4'($urandom_range(4)) + CIN_SYSEX_LO;
            if (p.cin > CIN_SYSEX_HI) p.cin = CIN_SINGLE;
        end
        r = $urandom_range(99);
        if (r < 60) p.status = {4'($urandom_range(EV_VOICE_HI, EV_VOICE_LO)), 4'($urandom)};
        else        p.status = 8'($urandom);
        p.cable = 4'($urandom);
        p.d1    = 8'($urandom);
        p.d2    = 8'($urandom);
        return p;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
            fault_count++;
        end
    endfunction

    task automatic drain();
        @(negedge clk);
        while (pending_pkts.size() != 0 || in_valid || fwd_expect.size() != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input int idx, input logic [PAIR_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx[CFG_IDX_W-1:0];
        cfg_data  <= data;
        if (idx < PAIR_REGS) route_copy[idx] = data;
    endtask

    task automatic commit_routes();
        drain();
        for (int k = 0; k < PAIR_REGS; k++) begin
            write_reg(k, {staged_nodes[2*k+1], staged_nodes[2*k]});
        end
        // unmapped index, must leave the table alone
        write_reg(PAIR_REGS + $urandom_range(CFG_SLOTS - 1 - PAIR_REGS),
                  PAIR_W'({$urandom, $urandom}));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_random(input int n);
        @(negedge clk);
        repeat (n) pending_pkts.push_back(rand_pkt());
    endtask

    // input driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !o_in_stall) begin
            if (in_valid) begin
                route_pkt(in_pkt);
            end
            if (pending_pkts.size() != 0 && (quiet || $urandom_range(99) >= 9)) begin
                in_pkt   <= pending_pkts.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // output monitor
    always @(posedge clk) begin
        if (rst_n && o_out_valid && !out_stall) begin
            if (fwd_expect.size() == 0) begin
                $display("%0t: unexpected item: expected none, actual port 0x%0h status 0x%0h",
                         $time, o_target_port, o_out_status);
                fault_count++;
            end else begin
                want_copy = fwd_expect.pop_front();
                check_field("target_port", want_copy.dport, o_target_port);
                check_field("code_index", want_copy.cin, o_out_code_index);
                check_field("cable", want_copy.cable, o_out_cable);
                check_field("status", want_copy.status, o_out_status);
                check_field("data_one", want_copy.d1, o_out_data_one);
                check_field("data_two", want_copy.d2, o_out_data_two);
                check_field("run_last", want_copy.last, o_run_last);
            end
        end
        out_stall <= !quiet && ($urandom_range(99) < 9);
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_CAP) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        logic [7:0] fan_port;
        for (int k = 0; k < PAIR_REGS; k++) route_copy[k] = PAIR_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset table: every node inactive
        @(negedge clk);
        pending_pkts.push_back(mk_pkt(8'h10, 4'h9, 4'h0, 8'h90, 8'h3c, 8'h7f));
        pending_pkts.push_back(mk_pkt(8'h10, 4'h0, 4'hf, 8'hf8, 8'h00, 8'h00));

        for (int i = 0; i < NODE_MAX; i++) staged_nodes[i] = '0;
        staged_nodes[0] = mk_node(8'h01, CHN_ALL,  8'ha0, CHN_ALL);
        staged_nodes[1] = mk_node(8'h01, 5'd1,     8'ha1, 5'd16);
        staged_nodes[2] = mk_node(8'h01, 5'd16,    8'ha2, 5'd1);
        staged_nodes[3] = mk_node(8'h01, 5'd20,    8'ha3, 5'd25);
        staged_nodes[4] = mk_node(8'h01, CHN_ALL,  8'ha4, 5'd5);
        staged_nodes[5] = mk_node(8'h01, CHN_NONE, 8'ha5, CHN_ALL);
        staged_nodes[6] = mk_node(8'h01, CHN_ALL,  8'ha6, CHN_NONE);
        staged_nodes[7] = mk_node(8'hff, 5'd31,    8'h00, 5'd31);
        staged_nodes[8] = mk_node(8'h00, CHN_ALL,  8'hff, CHN_ALL);
        commit_routes();

        @(negedge clk);
        pending_pkts.push_back(mk_pkt(8'h01, 4'h9, 4'h0, 8'h90, 8'h00, 8'h00));
        pending_pkts.push_back(mk_pkt(8'h01, 4'h8, 4'hf, 8'h8f, 8'hff, 8'hff));
        pending_pkts.push_back(mk_pkt(8'h01, 4'he, 4'h5, 8'hef, 8'h7f, 8'h7f));
        pending_pkts.push_back(mk_pkt(8'h01, 4'hb, 4'h3, 8'hb7, 8'h40, 8'h01));
        pending_pkts.push_back(mk_pkt(8'h01, 4'h2, 4'h0, 8'hf2, 8'h10, 8'h20));
        pending_pkts.push_back(mk_pkt(8'h01, 4'h0, 4'h0, 8'h00, 8'h00, 8'h00));
        pending_pkts.push_back(mk_pkt(8'h01, 4'h3, 4'h1, 8'h7f, 8'h12, 8'h34));
        pending_pkts.push_back(mk_pkt(8'h01, 4'h1, 4'h2, 8'hff, 8'h56, 8'h78));
        // sysex and single-byte packages are dropped
        pending_pkts.push_back(mk_pkt(8'h01, 4'h4, 4'h0, 8'h90, 8'h01, 8'h02));
        pending_pkts.push_back(mk_pkt(8'h01, 4'h5, 4'h0, 8'hf0, 8'h01, 8'h02));
        pending_pkts.push_back(mk_pkt(8'h01, 4'h6, 4'h0, 8'h80, 8'h01, 8'h02));
        pending_pkts.push_back(mk_pkt(8'h01, 4'h7, 4'h0, 8'hf7, 8'h01, 8'h02));
        pending_pkts.push_back(mk_pkt(8'h01, 4'hf, 4'h0, 8'hf8, 8'h01, 8'h02));
        pending_pkts.push_back(mk_pkt(8'h02, 4'h9, 4'h0, 8'h90, 8'h01, 8'h02));
        pending_pkts.push_back(mk_pkt(8'hff, 4'hc, 4'ha, 8'hc3, 8'h05, 8'h00));
        pending_pkts.push_back(mk_pkt(8'hff, 4'h2, 4'h0, 8'hf3, 8'h01, 8'h00));
        pending_pkts.push_back(mk_pkt(8'h00, 4'ha, 4'h0, 8'ha0, 8'h80, 8'h81));
        pending_pkts.push_back(mk_pkt(8'h00, 4'hd, 4'h0, 8'hd9, 8'haa, 8'h55));

        // all-zero table
        port_pool[0] = 8'h00;
        for (int k = 1; k < 4; k++) port_pool[k] = 8'($urandom);
        for (int i = 0; i < NODE_MAX; i++) staged_nodes[i] = '0;
        commit_routes();
        queue_random(15);

        // all-ones table
        port_pool[0] = 8'hff;
        for (int i = 0; i < NODE_MAX; i++) staged_nodes[i] = '1;
        commit_routes();
        queue_random(30);

        // every node forwards every channel from one port
        fan_port = 8'($urandom);
        for (int k = 0; k < 4; k++) port_pool[k] = fan_port;
        for (int i = 0; i < NODE_MAX; i++) begin
            staged_nodes[i] = mk_node(fan_port, CHN_ALL, 8'(i), CHN_ALL);
        end
        commit_routes();
        queue_random(30);

        for (int ph = 0; ph < 4; ph++) begin
            for (int k = 0; k < 4; k++) port_pool[k] = 8'($urandom);
            for (int i = 0; i < NODE_MAX; i++) staged_nodes[i] = rand_node();
            commit_routes();
            quiet = (ph == 2);
            queue_random(60);
        end

        drain();
        if (fault_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
